### hdl/polygon_tessellation_index_generator_assert.svh
// Assertion macros shared by the checker of the tessellation index generator.
// No dependencies; included by the checker file.
`ifndef POLYGON_TESSELLATION_INDEX_GENERATOR_ASSERT_SVH
`define POLYGON_TESSELLATION_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTIG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PTIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/ptig_pkg.sv
// Package of the tessellation index generator: limits, register indexes,
// the traversal state type and its start value. No dependencies.
`default_nettype none

package ptig_pkg;

    localparam int MAX_SIDES      = 16;
    localparam int MAX_RESOLUTION = 64;
    localparam int MIN_SIDES      = 3;

    localparam int SIDES_W = 5;
    localparam int RES_W   = 7;
    localparam int IDX_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd1;

    // Mode-selecting side counts.
    localparam logic [SIDES_W-1:0] SIDES_TRIANGLE = 5'd3;
    localparam logic [SIDES_W-1:0] SIDES_QUAD     = 5'd4;

    typedef struct packed {
        logic [RES_W-1:0]   layer_count;
        logic [RES_W-1:0]   column_count;
        logic [SIDES_W-1:0] side_index;
        logic               second_half;
        logic [IDX_W-1:0]   inner_base;
        logic [IDX_W-1:0]   outer_base;
        logic [IDX_W-1:0]   inner_cursor;
        logic [IDX_W-1:0]   outer_cursor;
    } ptig_state_t;

    // Effective configuration handed to the datapath, plus the clear pulse.
    typedef struct packed {
        logic [SIDES_W-1:0] sides;
        logic [RES_W-1:0]   res;
        logic               clear;
    } ptig_cfg_t;

    localparam ptig_state_t SEQ_START = '{
        layer_count:  '0,
        column_count: '0,
        side_index:   '0,
        second_half:  1'b0,
        inner_base:   16'd0,
        outer_base:   16'd1,
        inner_cursor: 16'd0,
        outer_cursor: 16'd1
    };

endpackage

`default_nettype wire

### hdl/polygon_tessellation_index_generator.sv
// Top level of the tessellation index generator: request register, state
// register, result register. Depends on ptig_pkg, ptig_cfg and ptig_step.
//
// Each item taken on the slave stream is a pull request (s_tdata bit 0 set
// restarts the mesh at its first triangle); each yields exactly one item on
// the master stream holding the next triangle's three vertex indices, with
// tlast marking the final triangle of the mesh, after which the sequence
// wraps. One request is accepted per clock cycle while the triangle stream
// is not stalled; the request register takes the request, and the result
// register then takes its triangle from the next-triangle logic once the
// result slot is free. Three sides gives triangular rows, four a quad grid,
// five to sixteen concentric layers around vertex 0. Configuration writes
// are always accepted, and a write to the side count or resolution
// register returns the sequence to the first triangle; they are to be
// made while no request is outstanding.
`default_nettype none

module polygon_tessellation_index_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ptig_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptig_pkg::CFG_DATA_W-1:0] cfg_data,
    // Request stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [0] restart
    // Triangle stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [47:0]                          m_tdata,  // vertex_a, vertex_b, vertex_c
    output logic                                 m_tlast   // last_triangle
);
    import ptig_pkg::*;

    ptig_cfg_t        cfg;
    ptig_state_t      state_reg;
    ptig_state_t      state_next;
    ptig_state_t      cur;
    logic             req_valid_reg;
    logic             req_restart_reg;
    logic             out_valid_reg;
    logic [47:0]      out_data_reg;
    logic             out_last_reg;
    logic [IDX_W-1:0] vertex_a;
    logic [IDX_W-1:0] vertex_b;
    logic [IDX_W-1:0] vertex_c;
    logic             last_triangle;
    logic             out_free;
    logic             advance;

    ptig_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A restart request begins from the first triangle.
    assign cur = req_restart_reg ? SEQ_START : state_reg;

    ptig_step u_step (
        .cur           (cur),
        .sides         (cfg.sides),
        .res           (cfg.res),
        .nxt           (state_next),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .last_triangle (last_triangle)
    );

    // Flow control: the request register drains whenever the result slot frees.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = req_valid_reg && out_free;
    assign s_tready = !req_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SEQ_START;
        end
        else
        begin
            if (s_tvalid && s_tready)
                req_valid_reg <= 1'b1;
            else if (advance)
                req_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg.clear)
                state_reg <= SEQ_START;
            else if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            req_restart_reg <= s_tdata[0];
        if (advance)
        begin
            out_data_reg <= {vertex_c, vertex_b, vertex_a};
            out_last_reg <= last_triangle;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hdl/ptig_cfg.sv
// Configuration registers of the tessellation index generator, with
// clamping of side count and resolution. Depends on ptig_pkg.
`default_nettype none

module ptig_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ptig_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptig_pkg::CFG_DATA_W-1:0] cfg_data,
    output ptig_pkg::ptig_cfg_t                 cfg
);
    import ptig_pkg::*;

    logic [SIDES_W-1:0] side_count_reg;
    logic [RES_W-1:0]   resolution_reg;
    logic               wr_sides;
    logic               wr_res;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign wr_sides  = cfg_valid && (cfg_index == REG_SIDE_COUNT);
    assign wr_res    = cfg_valid && (cfg_index == REG_RESOLUTION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= 5'd4;
            resolution_reg <= 7'd8;
        end
        else
        begin
            if (wr_sides)
                side_count_reg <= cfg_data[SIDES_W-1:0];
            if (wr_res)
                resolution_reg <= cfg_data[RES_W-1:0];
        end
    end

    // Clamp to the supported range; a write to the side count or resolution register restarts the mesh.
    always_comb
    begin
        if (side_count_reg < SIDES_W'(MIN_SIDES))
            cfg.sides = SIDES_W'(MIN_SIDES);
        else if (side_count_reg > SIDES_W'(MAX_SIDES))
            cfg.sides = SIDES_W'(MAX_SIDES);
        else
            cfg.sides = side_count_reg;

        if (resolution_reg == '0)
            cfg.res = RES_W'(1);
        else if (resolution_reg > RES_W'(MAX_RESOLUTION))
            cfg.res = RES_W'(MAX_RESOLUTION);
        else
            cfg.res = resolution_reg;

        cfg.clear = wr_sides || wr_res;
    end

endmodule

`default_nettype wire

### hdl/ptig_step.sv
// Next-triangle logic: from the traversal state and configuration, forms
// the three vertex indices, the last flag and the next state. Uses ptig_pkg.
`default_nettype none

module ptig_step (
    input  wire ptig_pkg::ptig_state_t              cur,
    input  wire logic [ptig_pkg::SIDES_W-1:0]       sides,
    input  wire logic [ptig_pkg::RES_W-1:0]         res,
    output ptig_pkg::ptig_state_t                   nxt,
    output logic [ptig_pkg::IDX_W-1:0]              vertex_a,
    output logic [ptig_pkg::IDX_W-1:0]              vertex_b,
    output logic [ptig_pkg::IDX_W-1:0]              vertex_c,
    output logic                                    last_triangle
);
    import ptig_pkg::*;

    logic [RES_W:0]     res_w;
    logic [RES_W:0]     layer;
    logic [RES_W:0]     col_inc;
    logic [SIDES_W:0]   side_inc;
    logic [IDX_W-1:0]   i_ext;
    logic [IDX_W-1:0]   j_ext;
    logic [IDX_W-1:0]   w_ext;
    logic [IDX_W-1:0]   quad_idx;
    logic [IDX_W-1:0]   oc_inc;
    logic [IDX_W-1:0]   ic_inc;
    logic               wrap;

    assign res_w    = {1'b0, res};
    assign layer    = {1'b0, cur.layer_count} + 1'b1;
    assign col_inc  = {1'b0, cur.column_count} + 1'b1;
    assign side_inc = {1'b0, cur.side_index} + 1'b1;
    assign i_ext    = IDX_W'(cur.layer_count);
    assign j_ext    = IDX_W'(cur.column_count);
    assign w_ext    = IDX_W'(res_w + 1'b1);
    assign quad_idx = cur.inner_base + j_ext;
    assign oc_inc   = cur.outer_cursor + 1'b1;
    assign ic_inc   = cur.inner_cursor + 1'b1;
    assign wrap     = (side_inc >= {1'b0, sides}) && (col_inc >= layer);

    always_comb
    begin
        nxt           = cur;
        last_triangle = 1'b0;
        vertex_a      = '0;
        vertex_b      = '0;
        vertex_c      = '0;

        case (sides)
            // Triangular rows: row i holds 2i+1 triangles.
            SIDES_TRIANGLE:
            begin
                if (cur.column_count < cur.layer_count)
                begin
                    if (!cur.second_half)
                    begin
                        vertex_a = cur.outer_base + j_ext;
                        vertex_b = cur.outer_base + j_ext + 1'b1;
                        vertex_c = cur.inner_base + j_ext;
                        nxt.second_half = 1'b1;
                    end
                    else
                    begin
                        vertex_a = cur.outer_base + j_ext + 1'b1;
                        vertex_b = cur.inner_base + j_ext + 1'b1;
                        vertex_c = cur.inner_base + j_ext;
                        nxt.second_half  = 1'b0;
                        nxt.column_count = col_inc[RES_W-1:0];
                    end
                end
                else
                begin
                    vertex_a = cur.outer_base + i_ext;
                    vertex_b = cur.outer_base + i_ext + 1'b1;
                    vertex_c = cur.inner_base + i_ext;
                    if (layer >= res_w)
                    begin
                        last_triangle = 1'b1;
                        nxt = SEQ_START;
                    end
                    else
                    begin
                        nxt.inner_base   = cur.outer_base;
                        nxt.outer_base   = cur.outer_base + i_ext + 16'd2;
                        nxt.layer_count  = layer[RES_W-1:0];
                        nxt.column_count = '0;
                        nxt.second_half  = 1'b0;
                    end
                end
            end

            // Quad grid: two triangles per cell, rows of res+1 vertices.
            SIDES_QUAD:
            begin
                if (!cur.second_half)
                begin
                    vertex_a = quad_idx;
                    vertex_b = quad_idx + w_ext;
                    vertex_c = quad_idx + 1'b1;
                    nxt.second_half = 1'b1;
                end
                else
                begin
                    vertex_a = quad_idx + 1'b1;
                    vertex_b = quad_idx + w_ext;
                    vertex_c = quad_idx + w_ext + 1'b1;
                    nxt.second_half  = 1'b0;
                    nxt.column_count = col_inc[RES_W-1:0];
                    if (col_inc >= res_w)
                    begin
                        nxt.column_count = '0;
                        nxt.layer_count  = layer[RES_W-1:0];
                        nxt.inner_base   = cur.inner_base + w_ext;
                        if (layer >= res_w)
                        begin
                            last_triangle = 1'b1;
                            nxt = SEQ_START;
                        end
                    end
                end
            end

            // Concentric layers around the centre vertex.
            default:
            begin
                vertex_a = cur.inner_cursor;
                vertex_b = cur.outer_cursor;
                if (!cur.second_half)
                begin
                    vertex_c = wrap ? cur.outer_base : oc_inc;
                    nxt.outer_cursor = oc_inc;
                    if (col_inc >= layer)
                    begin
                        nxt.column_count = '0;
                        if (side_inc >= {1'b0, sides})
                        begin
                            nxt.side_index = '0;
                            if (layer >= res_w)
                            begin
                                last_triangle = 1'b1;
                                nxt = SEQ_START;
                            end
                            else
                            begin
                                nxt.layer_count  = layer[RES_W-1:0];
                                nxt.inner_base   = cur.outer_base;
                                nxt.inner_cursor = cur.outer_base;
                                nxt.outer_base   = oc_inc;
                            end
                        end
                        else
                        begin
                            nxt.side_index = side_inc[SIDES_W-1:0];
                        end
                    end
                    else
                    begin
                        nxt.column_count = col_inc[RES_W-1:0];
                        nxt.second_half  = 1'b1;
                    end
                end
                else
                begin
                    vertex_c = wrap ? cur.inner_base : ic_inc;
                    nxt.inner_cursor = vertex_c;
                    nxt.second_half  = 1'b0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/ptig_checker.sv
// Port-level checker for the tessellation index generator, bound to the top.
// Depends on polygon_tessellation_index_generator_assert.svh.
`default_nettype none

`include "polygon_tessellation_index_generator_assert.svh"

module ptig_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled triangle holds its value.
    `PTIG_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Requests are refused only while a finished triangle is held back.
    `PTIG_ASSERT_IMPLY(a_refuse, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // An accepted request is followed by a triangle on offer.
    `PTIG_ASSERT_NEXT(a_latency, clk, rst_n, s_tvalid && s_tready, ##1 m_tvalid)

endmodule

bind polygon_tessellation_index_generator ptig_checker u_ptig_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
